>>> design/fqks_pkg.sv
// Shared types and codes for the keyed FIFO queue.
package fqks_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_SEARCH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD_RD,
      ST_HEAD_DONE,
      ST_SCAN
   } state_type;

   localparam int KEY_W = 32;
   localparam int HND_W = 32;

endpackage

>>> design/fifo_queue_with_key_search.sv
// Keyed FIFO queue: circular buffer in key/handle memories with sequential key scan.
// Remove/peek read the head entry through the registered read port, then load the response
// register (when empty, the response is loaded directly); insert/search scan the stored keys
// from head to tail, one memory read per cycle, and end early when a key matches.
// Throughput: one item in work at a time; a new request is taken only after the response is loaded.
// Reset (synchronous, active high) empties the queue; memory contents are not cleared.
module fifo_queue_with_key_search
   import fqks_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [HND_W-1:0]        req_record_handle,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [KEY_W-1:0] rsp_out_key,
   output logic [HND_W-1:0]        rsp_out_handle,
   output logic [CW-1:0]           rsp_entry_count,
   output logic                    rsp_is_empty
);

   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   logic [KEY_W-1:0] key_mem [QUEUE_DEPTH];
   logic [HND_W-1:0] hnd_mem [QUEUE_DEPTH];

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [HND_W-1:0] hnd_ff, hnd_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in, scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0] occ_ff, occ_in, issue_cnt_ff, issue_cnt_in;
   logic cmp_vld_ff, cmp_vld_in;

   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr;
   logic [KEY_W-1:0] key_rd_ff;
   logic [HND_W-1:0] hnd_rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [HND_W-1:0] rsp_hnd_ff, rsp_hnd_in;
   logic [CW-1:0]    rsp_cnt_ff, rsp_cnt_in;

   logic out_free, load, hit, miss;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + AW'(1);
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = cmp_vld_ff && (key_rd_ff == key_ff);
   assign miss     = !hit && (issue_cnt_ff == occ_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      hnd_in       = hnd_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      scan_ptr_in  = scan_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_vld_in   = cmp_vld_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ptr_ff;
      wr_en        = 1'b0;
      load         = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = cmd_type'(req_command);
               key_in = req_key;
               hnd_in = req_record_handle;
               if (cmd_type'(req_command) == CMD_INSERT ||
                   cmd_type'(req_command) == CMD_SEARCH) begin
                  scan_ptr_in  = head_ff;
                  issue_cnt_in = '0;
                  cmp_vld_in   = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end
         ST_HEAD_RD: begin
            if (occ_ff == '0) begin
               if (out_free) begin
                  load          = 1'b1;
                  rsp_status_in = STAT_EMPTY;
                  rsp_key_in    = '0;
                  rsp_hnd_in    = '0;
                  state_in      = ST_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_HEAD_DONE;
            end
         end
         ST_HEAD_DONE: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_key_in    = key_rd_ff;
               rsp_hnd_in    = hnd_rd_ff;
               if (cmd_ff == CMD_REMOVE) begin
                  head_in = next_idx(head_ff);
                  occ_in  = occ_ff - CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (hit || miss) begin
               if (out_free) begin
                  load       = 1'b1;
                  rsp_key_in = '0;
                  rsp_hnd_in = '0;
                  state_in   = ST_IDLE;
                  if (cmd_ff == CMD_SEARCH) begin
                     if (hit) begin
                        rsp_status_in = STAT_OK;
                        rsp_key_in    = key_rd_ff;
                        rsp_hnd_in    = hnd_rd_ff;
                     end else begin
                        rsp_status_in = STAT_EMPTY;
                     end
                  end else if (hit) begin
                     rsp_status_in = STAT_DUP;
                  end else if (occ_ff == FULL_CNT) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_status_in = STAT_OK;
                     wr_en         = 1'b1;
                     tail_in       = next_idx(tail_ff);
                     occ_in        = occ_ff + CW'(1);
                  end
               end
            end else begin
               rd_en        = 1'b1;
               rd_addr      = scan_ptr_ff;
               scan_ptr_in  = next_idx(scan_ptr_ff);
               issue_cnt_in = issue_cnt_ff + CW'(1);
               cmp_vld_in   = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_cnt_in   = load ? occ_in : rsp_cnt_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      hnd_ff        <= hnd_in;
      scan_ptr_ff   <= scan_ptr_in;
      issue_cnt_ff  <= issue_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_hnd_ff    <= rsp_hnd_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[tail_ff] <= key_ff;
         hnd_mem[tail_ff] <= hnd_ff;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         hnd_rd_ff <= hnd_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_handle  = rsp_hnd_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_is_empty    = (rsp_cnt_ff == '0);

endmodule

>>> tb/fifo_queue_with_key_search_test.sv
// Self-checking testbench for the keyed FIFO queue: directed and random commands, random idling.
module fifo_queue_with_key_search_test;
   import fqks_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct {
      status_type              status;
      logic signed [KEY_W-1:0] key;
      logic [HND_W-1:0]        handle;
      logic [CW-1:0]           count;
      logic                    empty;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = CMD_INSERT;
   logic signed [KEY_W-1:0] req_key = '0;
   logic [HND_W-1:0] req_record_handle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic signed [KEY_W-1:0] rsp_out_key;
   logic [HND_W-1:0] rsp_out_handle;
   logic [CW-1:0] rsp_entry_count;
   logic rsp_is_empty;

   // queue shadow
   logic signed [KEY_W-1:0] stored_keys [DEPTH];
   logic [HND_W-1:0] stored_handles [DEPTH];
   int head_pos = 0;
   int tail_pos = 0;
   int fill_level = 0;

   queue_result_type pending_results[$];
   int error_count = 0;
   bit steady_flow = 1'b0;

   fifo_queue_with_key_search #(.QUEUE_DEPTH(DEPTH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_key(req_key),
      .req_record_handle(req_record_handle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key),
      .rsp_out_handle(rsp_out_handle),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_empty(rsp_is_empty)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void predict_queue_result(cmd_type cmd, logic signed [KEY_W-1:0] key,
                                                logic [HND_W-1:0] handle);
      queue_result_type r;
      bit found;
      int pos;
      int idx;
      found = 1'b0;
      pos = 0;
      r.status = STAT_OK;
      r.key = '0;
      r.handle = '0;
      for (int n = 0; n < fill_level; n++) begin
         idx = (head_pos + n) % DEPTH;
         if (!found && stored_keys[idx] == key) begin
            found = 1'b1;
            pos = idx;
         end
      end
      case (cmd)
         CMD_INSERT: begin
            if (found) begin
               r.status = STAT_DUP;
            end else if (fill_level >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               stored_keys[tail_pos] = key;
               stored_handles[tail_pos] = handle;
               tail_pos = (tail_pos + 1) % DEPTH;
               fill_level++;
            end
         end
         CMD_REMOVE: begin
            if (fill_level == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.key = stored_keys[head_pos];
               r.handle = stored_handles[head_pos];
               head_pos = (head_pos + 1) % DEPTH;
               fill_level--;
            end
         end
         CMD_PEEK: begin
            if (fill_level == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.key = stored_keys[head_pos];
               r.handle = stored_handles[head_pos];
            end
         end
         default: begin
            if (found) begin
               r.key = stored_keys[pos];
               r.handle = stored_handles[pos];
            end else begin
               r.status = STAT_EMPTY;
            end
         end
      endcase
      r.count = CW'(fill_level);
      r.empty = (fill_level == 0);
      pending_results.push_back(r);
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("%0t: %s got %0h, expected %0h", $realtime, field, got, want);
   endtask

   task automatic send_item(cmd_type cmd, logic signed [KEY_W-1:0] key,
                            logic [HND_W-1:0] handle);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= key;
      req_record_handle <= handle;
      do @(posedge clock); while (!req_ready);
      predict_queue_result(cmd, key, handle);
   endtask

   // hold off new transfers until every expected result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && fill_level > 0)
         return stored_keys[(head_pos + $urandom_range(0, fill_level - 1)) % DEPTH];
      if (r < 80) return KEY_W'($urandom_range(0, 31)) - 16;
      if (r < 86) begin
         case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic cmd_type pick_command(int insert_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) return CMD_INSERT;
      r = $urandom_range(0, 9);
      if (r < 5) return CMD_REMOVE;
      if (r < 7) return CMD_PEEK;
      return CMD_SEARCH;
   endfunction

   task automatic send_random(int count, int period);
      int insert_pct;
      insert_pct = 70;
      for (int i = 0; i < count; i++) begin
         if (i % period == 0) insert_pct = (insert_pct > 50) ? 25 : 70;
         send_item(pick_command(insert_pct), pick_key(), $urandom);
      end
   endtask

   task automatic test_empty_queue();
      send_item(CMD_REMOVE, '0, '0);
      send_item(CMD_PEEK, '0, '0);
      send_item(CMD_SEARCH, KEY_MIN, 32'hffff_ffff);
   endtask

   task automatic test_fill_to_full();
      send_item(CMD_INSERT, KEY_MIN, 32'h0000_0000);
      send_item(CMD_INSERT, KEY_MAX, 32'hffff_ffff);
      send_item(CMD_INSERT, '0, 32'h5555_5555);
      send_item(CMD_INSERT, -1, 32'haaaa_aaaa);
      for (int i = 4; i < DEPTH; i++) send_item(CMD_INSERT, KEY_W'(i * 1000 + 5000), $urandom);
      send_item(CMD_INSERT, 32'sd12345, $urandom);
      send_item(CMD_INSERT, KEY_MAX, $urandom);
      send_item(CMD_PEEK, '0, '0);
      send_item(CMD_SEARCH, stored_keys[(tail_pos + DEPTH - 1) % DEPTH], '0);
      send_item(CMD_SEARCH, 32'sd12345, '0);
      send_item(CMD_REMOVE, '0, '0);
   endtask

   task automatic test_random_mix();
      send_random(1200, 40);
   endtask

   task automatic test_back_to_back();
      steady_flow = 1'b1;
      send_random(400, 24);
      steady_flow = 1'b0;
   endtask

   task automatic test_fill_drain_cycles();
      send_random(400, 60);
   endtask

   initial begin : rsp_stall
      int r;
      int len;
      forever begin
         if (steady_flow) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) len = $urandom_range(1, 8);
            else if (r < 95) len = $urandom_range(1, 3);
            else len = $urandom_range(15, 40);
            @(negedge clock);
            rsp_ready <= (r < 60);
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer, status", 32'(rsp_status), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_out_key !== want.key)
               report_mismatch("out_key", rsp_out_key, want.key);
            if (rsp_out_handle !== want.handle)
               report_mismatch("out_handle", rsp_out_handle, want.handle);
            if (rsp_entry_count !== want.count)
               report_mismatch("entry_count", 32'(rsp_entry_count), 32'(want.count));
            if (rsp_is_empty !== want.empty)
               report_mismatch("is_empty", 32'(rsp_is_empty), 32'(want.empty));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_fill_to_full();
      test_random_mix();
      wait_for_results();
      test_back_to_back();
      wait_for_results();
      test_fill_drain_cycles();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> fifo_queue_with_key_search.f
design/fqks_pkg.sv
design/fifo_queue_with_key_search.sv
tb/fifo_queue_with_key_search_test.sv
